@@ sv/assert_macros.svh @@
// Assertion macros for the servo scan controller RTL, used by ssc_core.
// Users must have signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside of reset.
`define SSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define SSC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/ssc_pkg.sv @@
// Shared types, codes and constants for the servo scan/slew controller.
// No dependencies; used by every other RTL module and interface file.
package ssc_pkg;

   localparam logic [7:0] HOME_ANGLE  = 8'd90;
   localparam logic [7:0] FULL_SWING  = 8'd180;
   localparam longint     DUTY_MIN_NS = 500000;
   localparam longint     DUTY_MAX_NS = 2500000;
   localparam int         RANDOM_BITS_DEF = 8;

   localparam int KIND_W      = 3;
   localparam int RND_W       = 8;
   localparam int DUTY_W      = 22;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // per-degree duty increment, split into quotient and remainder over full swing
   localparam longint DUTY_SPAN     = DUTY_MAX_NS - DUTY_MIN_NS;
   localparam longint DUTY_SPAN_ABS = (DUTY_SPAN < 0) ? -DUTY_SPAN : DUTY_SPAN;
   localparam longint DUTY_STEP_Q   = DUTY_SPAN_ABS / longint'(FULL_SWING);
   localparam longint DUTY_STEP_R   = DUTY_SPAN_ABS % longint'(FULL_SWING);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK       = 3'd0,
      KIND_START      = 3'd1,
      KIND_STOP       = 3'd2,
      KIND_HOME       = 3'd3,
      KIND_LOOK_LEFT  = 3'd4,
      KIND_LOOK_RIGHT = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      PH_LEFT  = 2'd0,
      PH_MID_L = 2'd1,
      PH_RIGHT = 2'd2,
      PH_MID_R = 2'd3
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP        = 3'd0,
      CSR_LEFT_LOW    = 3'd1,
      CSR_LEFT_HIGH   = 3'd2,
      CSR_RIGHT_LOW   = 3'd3,
      CSR_RIGHT_HIGH  = 3'd4,
      CSR_MIDDLE_LOW  = 3'd5,
      CSR_MIDDLE_HIGH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] step;
      logic [7:0] left_low;
      logic [7:0] left_high;
      logic [7:0] right_low;
      logic [7:0] right_high;
      logic [7:0] middle_low;
      logic [7:0] middle_high;
   } cfg_type;

   typedef struct packed {
      logic [7:0] angle;
      logic [7:0] target;
      logic       scan;
      phase_type  phase;
   } state_type;

   typedef logic [DUTY_W-1:0] duty_table_type [256];

   // duty = min + angle*span/180, truncated toward zero, wrapped to the field width;
   // angle*|span|/180 is walked one degree at a time as quotient plus remainder
   function automatic duty_table_type build_duty_table();
      duty_table_type tab;
      longint         q;
      longint         r;
      longint         d;
      q = 0;
      r = 0;
      for (int i = 0; i < 256; i++) begin
         d = DUTY_MIN_NS + ((DUTY_SPAN < 0) ? -q : q);
         tab[i] = d[DUTY_W-1:0];
         // angles above full swing keep the full-swing value
         if (i < int'(FULL_SWING)) begin
            q = q + DUTY_STEP_Q;
            r = r + DUTY_STEP_R;
            if (r >= longint'(FULL_SWING)) begin
               q = q + 1;
               r = r - longint'(FULL_SWING);
            end
         end
      end
      return tab;
   endfunction

   localparam duty_table_type DUTY_TABLE = build_duty_table();

endpackage

@@ sv/ssc_req_if.sv @@
// Input channel of the servo scan controller: valid/ready plus kind and rnd.
// Depends on ssc_pkg for field widths.
interface ssc_req_if import ssc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [RND_W-1:0]  rnd;

   modport source (output valid, output kind, output rnd, input ready);
   modport sink   (input valid, input kind, input rnd, output ready);
endinterface

@@ sv/ssc_rsp_if.sv @@
// Result channel of the servo scan controller: valid/ready plus duty and status.
// Depends on ssc_pkg for field widths.
interface ssc_rsp_if import ssc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_ns;
   logic [7:0]        angle_now;
   logic              scan_on;
   logic [1:0]        phase_now;

   modport source (output valid, output duty_ns, output angle_now, output scan_on,
                   output phase_now, input ready);
   modport sink   (input valid, input duty_ns, input angle_now, input scan_on,
                   input phase_now, output ready);
endinterface

@@ sv/ssc_csr_regs.sv @@
// Configuration register bank (step size and the three phase ranges).
// Depends on ssc_pkg.
module ssc_csr_regs import ssc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index_sel;

   assign index_sel = csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (index_sel)
            CSR_STEP:        cfg_in.step        = csr_wdata;
            CSR_LEFT_LOW:    cfg_in.left_low    = csr_wdata;
            CSR_LEFT_HIGH:   cfg_in.left_high   = csr_wdata;
            CSR_RIGHT_LOW:   cfg_in.right_low   = csr_wdata;
            CSR_RIGHT_HIGH:  cfg_in.right_high  = csr_wdata;
            CSR_MIDDLE_LOW:  cfg_in.middle_low  = csr_wdata;
            CSR_MIDDLE_HIGH: cfg_in.middle_high = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step        <= 8'd2;
         cfg_ff.left_low    <= 8'd30;
         cfg_ff.left_high   <= 8'd60;
         cfg_ff.right_low   <= 8'd120;
         cfg_ff.right_high  <= 8'd150;
         cfg_ff.middle_low  <= 8'd75;
         cfg_ff.middle_high <= 8'd105;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/ssc_draw.sv @@
// Random target draw: lo + ((r * (hi-lo+1)) >> RANDOM_BITS), or lo if hi < lo, saturated to full swing.
// Depends on ssc_pkg.
module ssc_draw import ssc_pkg::*; #(
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
   input  logic [7:0]       lo,
   input  logic [7:0]       hi,
   input  logic [RND_W-1:0] rnd,
   output logic [7:0]       target
);

   // only the low RANDOM_BITS of rnd matter, and rnd has RND_W bits
   localparam int RndW  = (RANDOM_BITS < RND_W) ? RANDOM_BITS : RND_W;
   localparam int ProdW = RndW + 9;

   logic [RndW-1:0]  r;
   logic [8:0]       span;
   logic [ProdW-1:0] prod;
   logic [ProdW-1:0] scaled;
   logic [8:0]       sum;
   logic [8:0]       pick;

   assign r      = rnd[RndW-1:0];
   assign span   = {1'b0, hi} - {1'b0, lo} + 9'd1;
   assign prod   = ProdW'(r) * ProdW'(span);
   // scaled < span <= 256 whenever hi >= lo, so 8 bits hold it
   assign scaled = prod >> RANDOM_BITS;
   assign sum    = {1'b0, lo} + {1'b0, scaled[7:0]};
   assign pick   = (hi < lo) ? {1'b0, lo} : sum;
   assign target = (pick > {1'b0, FULL_SWING}) ? FULL_SWING : pick[7:0];

endmodule

@@ sv/ssc_core.sv @@
// Slew/scan state: angle, target, scan flag and phase, updated once per transaction.
// Depends on ssc_pkg, ssc_draw and assert_macros.svh.
`include "assert_macros.svh"
module ssc_core import ssc_pkg::*; #(
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [KIND_W-1:0] kind,
   input  logic [RND_W-1:0]  rnd,
   input  cfg_type           cfg,
   output state_type         state_next
);

   state_type  state_ff;
   state_type  state_in;
   kind_type   kind_sel;
   logic [8:0] step_sum;
   logic [7:0] step_diff;
   logic [7:0] angle_step;
   logic       reached;
   phase_type  phase_adv;
   phase_type  draw_phase;
   logic [7:0] range_lo;
   logic [7:0] range_hi;
   logic [7:0] drawn;

   assign kind_sel  = kind_type'(kind);
   assign step_sum  = {1'b0, state_ff.angle} + {1'b0, cfg.step};
   assign step_diff = state_ff.angle - state_ff.target;

   always_comb begin
      angle_step = state_ff.angle;
      if (state_ff.angle < state_ff.target) begin
         angle_step = (step_sum < {1'b0, state_ff.target}) ? step_sum[7:0] : state_ff.target;
      end else if (state_ff.angle > state_ff.target) begin
         angle_step = (step_diff > cfg.step) ? state_ff.angle - cfg.step : state_ff.target;
      end
   end

   assign reached   = (angle_step == state_ff.target) && state_ff.scan;
   assign phase_adv = phase_type'(state_ff.phase + 2'd1);

   // one draw unit, range chosen by the phase the new target belongs to
   always_comb begin
      case (kind_sel)
         KIND_TICK:       draw_phase = phase_adv;
         KIND_LOOK_RIGHT: draw_phase = PH_RIGHT;
         default:         draw_phase = PH_LEFT;
      endcase
      case (draw_phase)
         PH_LEFT: begin
            range_lo = cfg.left_low;
            range_hi = cfg.left_high;
         end
         PH_RIGHT: begin
            range_lo = cfg.right_low;
            range_hi = cfg.right_high;
         end
         default: begin
            range_lo = cfg.middle_low;
            range_hi = cfg.middle_high;
         end
      endcase
   end

   ssc_draw #(
      .RANDOM_BITS (RANDOM_BITS)
   ) u_draw (
      .lo     (range_lo),
      .hi     (range_hi),
      .rnd    (rnd),
      .target (drawn)
   );

   always_comb begin
      state_in = state_ff;
      unique case (kind_sel) inside
         KIND_TICK: begin
            state_in.angle = angle_step;
            if (reached) begin
               state_in.phase  = phase_adv;
               state_in.target = drawn;
            end
         end
         KIND_START: begin
            if (!state_ff.scan) begin
               state_in.scan   = 1'b1;
               state_in.phase  = PH_LEFT;
               state_in.target = drawn;
            end
         end
         KIND_STOP, KIND_HOME: begin
            state_in.scan   = 1'b0;
            state_in.phase  = PH_LEFT;
            state_in.target = HOME_ANGLE;
         end
         KIND_LOOK_LEFT, KIND_LOOK_RIGHT: begin
            state_in.scan   = 1'b0;
            state_in.target = drawn;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.angle  <= HOME_ANGLE;
         state_ff.target <= HOME_ANGLE;
         state_ff.scan   <= 1'b0;
         state_ff.phase  <= PH_LEFT;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

   `SSC_ASSERT(a_angle_in_range, state_ff.angle <= FULL_SWING, "angle above full swing")
   `SSC_ASSERT(a_event_keeps_angle, accept && kind_sel != KIND_TICK |=> $stable(state_ff.angle), "event moved the angle")
   `SSC_ASSERT(a_stop_goes_home, accept && (kind_sel == KIND_STOP || kind_sel == KIND_HOME) |=> !state_ff.scan && state_ff.target == HOME_ANGLE && state_ff.phase == PH_LEFT, "stop/home did not reset target")

endmodule

@@ sv/servo_scan_slew_controller.sv @@
// Servo scan/slew controller top level.
// The result of an accepted transaction is in the output register from the next cycle on.
// Throughput: one transaction per cycle while each result is taken; the state update and duty lookup are combinational.
// The output register frees the input side as soon as its result is taken (or same cycle).
// Reset (synchronous): angle and target home, scan off, left phase, registers to defaults.
module servo_scan_slew_controller import ssc_pkg::*; #(
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ssc_req_if.sink                req_if,
   ssc_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type           cfg;
   state_type         state_next;
   logic              accept;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DUTY_W-1:0] duty_ff;
   logic [7:0]        angle_ff;
   logic              scan_ff;
   logic [1:0]        phase_ff;

   ssc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssc_core #(
      .RANDOM_BITS (RANDOM_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_if.kind),
      .rnd        (req_if.rnd),
      .cfg        (cfg),
      .state_next (state_next)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         duty_ff  <= DUTY_TABLE[state_next.angle];
         angle_ff <= state_next.angle;
         scan_ff  <= state_next.scan;
         phase_ff <= state_next.phase;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.duty_ns   = duty_ff;
   assign rsp_if.angle_now = angle_ff;
   assign rsp_if.scan_on   = scan_ff;
   assign rsp_if.phase_now = phase_ff;

endmodule
